// File: rtl/core/sud_pkg.sv
// ----------------------------------------------------------------------------
// sud_pkg
// Shared constants and types for the signed/unsigned divider core.
// ----------------------------------------------------------------------------
package sud_pkg;

	// Default operand width
	localparam int DATA_WIDTH = 32;

	// Control that travels beside the data through the entry stage and every cell
	typedef struct packed {
		logic valid;  // stage holds a live item
		logic neg_q;  // negate quotient at the end
		logic neg_r;  // negate remainder at the end
	} ctl_t;

endpackage

// File: rtl/core/sud_cell.sv
// ----------------------------------------------------------------------------
// sud_cell
// One restoring-division step: shift in the next dividend bit, trial
// subtract the divisor, keep or restore, and shift the quotient bit in.
// ----------------------------------------------------------------------------
module sud_cell #(
	parameter int DATA_WIDTH = sud_pkg::DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sud_pkg::ctl_t         ctl_in,
	input  logic [DATA_WIDTH-1:0] acc_in,   // partial remainder
	input  logic [DATA_WIDTH-1:0] nq_in,    // dividend bits left, quotient bits in
	input  logic [DATA_WIDTH-1:0] d_in,     // divisor magnitude
	output sud_pkg::ctl_t         ctl_out,
	output logic [DATA_WIDTH-1:0] acc_out,
	output logic [DATA_WIDTH-1:0] nq_out,
	output logic [DATA_WIDTH-1:0] d_out
);

	sud_pkg::ctl_t         ctl_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] nq_q;
	logic [DATA_WIDTH-1:0] d_q;

	logic [DATA_WIDTH-1:0] shifted;
	logic [DATA_WIDTH-1:0] diff;
	logic                  carry;
	logic                  take;

	// Trial subtract; the bit shifted out of the top always forces a take
	always_comb begin
		carry   = acc_in[DATA_WIDTH-1];
		shifted = {acc_in[DATA_WIDTH-2:0], nq_in[DATA_WIDTH-1]};
		diff    = shifted - d_in;
		take    = carry || (shifted >= d_in);
	end

	// Control: valid cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	// Data path, no reset
	always_ff @(posedge clk) begin
		acc_q <= take ? diff : shifted;
		nq_q  <= {nq_in[DATA_WIDTH-2:0], take};
		d_q   <= d_in;
	end

	assign ctl_out = ctl_q;
	assign acc_out = acc_q;
	assign nq_out  = nq_q;
	assign d_out   = d_q;

endmodule

// File: rtl/core/signed_unsigned_divider_core.sv
// ----------------------------------------------------------------------------
// signed_unsigned_divider_core
// Pipelined restoring divider, unsigned or two's complement signed.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with op, dividend and divisor; the item is taken on any
//   edge where start is high and busy is low. busy is never raised, so an
//   item can be issued every cycle.
//   op = 0 divides unsigned, op = 1 divides signed: the quotient truncates
//   toward zero and the remainder carries the dividend's sign.
//   Divide by zero gives quotient magnitude all ones (sign applied) and
//   remainder equal to the dividend.
//   Pipeline: one magnitude stage, one cell per quotient bit, one sign-fix
//   stage. Throughput is one item per cycle.
//   Each result sits on quotient/remainder for exactly one cycle with done
//   high; the receiver cannot stall it.
//   Reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_core #(
	parameter int DATA_WIDTH = sud_pkg::DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  op,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);

	logic                  n_neg;
	logic                  d_neg;
	logic [DATA_WIDTH-1:0] n_mag;
	logic [DATA_WIDTH-1:0] d_mag;

	sud_pkg::ctl_t         ctl_s0;
	logic [DATA_WIDTH-1:0] nq_s0;
	logic [DATA_WIDTH-1:0] d_s0;

	sud_pkg::ctl_t                    ctl_c [DATA_WIDTH+1];
	logic [DATA_WIDTH:0][DATA_WIDTH-1:0] acc_c;
	logic [DATA_WIDTH:0][DATA_WIDTH-1:0] nq_c;
	logic [DATA_WIDTH:0][DATA_WIDTH-1:0] d_c;

	logic [DATA_WIDTH-1:0] q_fix;
	logic [DATA_WIDTH-1:0] r_fix;
	logic                  done_q;
	logic [DATA_WIDTH-1:0] quotient_q;
	logic [DATA_WIDTH-1:0] remainder_q;

	assign busy = 1'b0;

	// Operand magnitudes and result signs
	always_comb begin
		n_neg = op && dividend[DATA_WIDTH-1];
		d_neg = op && divisor[DATA_WIDTH-1];
		n_mag = n_neg ? (~dividend + DATA_WIDTH'(1)) : dividend;
		d_mag = d_neg ? (~divisor + DATA_WIDTH'(1)) : divisor;
	end

	// Entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else begin
			ctl_s0.valid <= start && !busy;
			ctl_s0.neg_q <= n_neg ^ d_neg;
			ctl_s0.neg_r <= n_neg;
		end
	end

	always_ff @(posedge clk) begin
		nq_s0 <= n_mag;
		d_s0  <= d_mag;
	end

	assign ctl_c[0] = ctl_s0;
	assign acc_c[0] = '0;
	assign nq_c[0]  = nq_s0;
	assign d_c[0]   = d_s0;

	// Row of division cells, one per quotient bit
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		sud_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[i]),
			.acc_in  (acc_c[i]),
			.nq_in   (nq_c[i]),
			.d_in    (d_c[i]),
			.ctl_out (ctl_c[i+1]),
			.acc_out (acc_c[i+1]),
			.nq_out  (nq_c[i+1]),
			.d_out   (d_c[i+1])
		);
	end

	// Sign fix and output register
	always_comb begin
		q_fix = ctl_c[DATA_WIDTH].neg_q ?
			(~nq_c[DATA_WIDTH] + DATA_WIDTH'(1)) : nq_c[DATA_WIDTH];
		r_fix = ctl_c[DATA_WIDTH].neg_r ?
			(~acc_c[DATA_WIDTH] + DATA_WIDTH'(1)) : acc_c[DATA_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_c[DATA_WIDTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		quotient_q  <= q_fix;
		remainder_q <= r_fix;
	end

	assign done      = done_q;
	assign quotient  = quotient_q;
	assign remainder = remainder_q;

endmodule

// File: rtl/core/sud_checker.sv
// ----------------------------------------------------------------------------
// sud_checker
// Port-level checks for the divider core, bound to the top level.
// ----------------------------------------------------------------------------
module sud_checker #(
	parameter int DATA_WIDTH = sud_pkg::DATA_WIDTH
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  op,
	input logic [DATA_WIDTH-1:0] dividend,
	input logic [DATA_WIDTH-1:0] divisor,
	input logic                  done,
	input logic [DATA_WIDTH-1:0] quotient,
	input logic [DATA_WIDTH-1:0] remainder
);

	localparam int LAT = DATA_WIDTH + 2;
	localparam int CW  = $clog2(LAT + 1);

	logic [CW-1:0] age_q;
	logic          warm;

	// Cycles since reset, saturating at the latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != CW'(LAT)) begin
			age_q <= age_q + CW'(1);
		end
	end

	assign warm = (age_q == CW'(LAT));

	// Never holds off an item
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// One done pulse per accepted item
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LAT)))
		else $error("done does not match accepted item");

	// Divide by zero returns the dividend as remainder
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && $past(divisor == '0, LAT)) |-> (remainder == $past(dividend, LAT)))
		else $error("divide by zero remainder");

	// Unsigned remainder below a nonzero divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && $past(!op && divisor != '0, LAT)) |->
		(remainder < $past(divisor, LAT)))
		else $error("unsigned remainder out of range");

	// Unsigned divide by one passes the dividend through
	a_div_one: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && $past(!op && divisor == DATA_WIDTH'(1), LAT)) |->
		(quotient == $past(dividend, LAT) && remainder == '0))
		else $error("unsigned divide by one");

endmodule

bind signed_unsigned_divider_core sud_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_sud_checker (.*);
